### rtl/sha256_pkg.sv
`timescale 1ns / 1ps
package sha256_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic       buf_write;   // write buf_data at buf_addr
		logic [5:0] buf_addr;
		logic [7:0] buf_data;
		logic       count_inc;
		logic       count_clear;
		logic       load;        // load working vars
		logic       round;       // run one round
		logic [5:0] round_idx;
		logic       fold;        // add working vars into hash words
		logic       hash_init;
		logic [2:0] rd_idx;      // digest word select
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0]  pos;        // byte_count mod 64
		logic [63:0] bit_len;    // message length in bits
		logic [31:0] rd_word;
	} dp_stat_t;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

endpackage

### rtl/sha256_datapath.sv
`timescale 1ns / 1ps
module sha256_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha256_pkg::dp_cmd_t  cmd,
	output sha256_pkg::dp_stat_t stat
);
	import sha256_pkg::*;

	// block bytes land straight in the schedule window, big-endian within a word
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [63:0] count_q;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	logic [31:0] w_new, w_cur, t1, t2, s0, s1;

	always_comb begin
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		// window rotates W[0..15] in the first 16 rounds, which read the loaded words; from round 16 it holds W[t-16..t-1]
		w_cur = (cmd.round_idx < 6'd16) ? w_q[0] : w_new;
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + ROUND_K[cmd.round_idx] + w_cur;
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (cmd.buf_write) begin
			w_q[cmd.buf_addr[5:2]][{~cmd.buf_addr[1:0], 3'b000} +: 8] <= cmd.buf_data;
		end else if (cmd.load) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (cmd.round) begin
			// shift the window every round; from round 16 on, computed words enter it
			if (cmd.round_idx < 6'd16) begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= w_q[0];
			end else begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= w_new;
			end
			for (int i = 1; i < 8; i++) begin
				if (i != 4) v_q[i] <= v_q[i-1];
			end
			v_q[4] <= v_q[3] + t1;
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= INIT_HASH[i];
			count_q <= '0;
		end else begin
			if (cmd.hash_init) begin
				for (int i = 0; i < 8; i++) h_q[i] <= INIT_HASH[i];
			end else if (cmd.fold) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			end
			if (cmd.count_clear) begin
				count_q <= '0;
			end else if (cmd.count_inc) begin
				count_q <= count_q + 64'd1;
			end
		end
	end

	assign stat.pos     = count_q[5:0];
	assign stat.bit_len = {count_q[60:0], 3'b000};
	assign stat.rd_word = h_q[cmd.rd_idx];
endmodule

### rtl/sha256_controller.sv
`timescale 1ns / 1ps
module sha256_controller (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha256_pkg::in_item_t  in_item,
	input  logic                  in_valid,
	output logic                  in_ready,
	output sha256_pkg::out_item_t out_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  sha256_pkg::dp_stat_t  stat,
	output sha256_pkg::dp_cmd_t   cmd
);
	import sha256_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LOAD  = 7'b0000010,
		ST_ROUND = 7'b0000100,
		ST_FOLD  = 7'b0001000,
		ST_PAD   = 7'b0010000,
		ST_OUT   = 7'b0100000,
		ST_WAIT  = 7'b1000000
	} state_t;

	state_t     state_q, state_d;
	logic [5:0] rnd_q;
	logic [5:0] pad_q;       // next padding byte address
	logic       finish_q;    // message end pending
	logic       len_done_q;  // final block carries the length
	logic       tail_q;      // extra block holding only zeros and the length
	logic [2:0] idx_q;

	logic accept;
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.round_idx = rnd_q;
		cmd.rd_idx    = idx_q;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_item.byte_present) begin
						cmd.buf_write = 1'b1;
						cmd.buf_addr  = stat.pos;
						cmd.buf_data  = in_item.data_byte;
						cmd.count_inc = 1'b1;
					end
					if (in_item.byte_present && stat.pos == 6'd63) begin
						state_d = ST_LOAD;
					end else if (in_item.end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.buf_write = 1'b1;
				cmd.buf_addr  = pad_q;
				if (pad_q == stat.pos && !tail_q) begin
					cmd.buf_data = PAD_BYTE;
				end else if (pad_q >= LEN_POS && (stat.pos < LEN_POS || tail_q)) begin
					cmd.buf_data = stat.bit_len[8'd63 - {2'b0, pad_q[2:0], 3'b0} -: 8];
				end else begin
					cmd.buf_data = 8'h00;
				end
				if (pad_q == 6'd63) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (rnd_q == 6'd63) state_d = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				if (!finish_q) begin
					state_d = ST_IDLE;
				end else if (len_done_q) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_OUT: begin
				if (out_ready && idx_q == 3'd7) begin
					cmd.hash_init   = 1'b1;
					cmd.count_clear = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_WAIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid             = (state_q == ST_OUT);
	assign out_item.digest_word  = stat.rd_word;
	assign out_item.word_index   = idx_q;
	assign out_item.last_word    = (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rnd_q      <= '0;
			pad_q      <= '0;
			finish_q   <= 1'b0;
			len_done_q <= 1'b0;
			tail_q     <= 1'b0;
			idx_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && accept) begin
				finish_q   <= in_item.end_of_message;
				len_done_q <= 1'b0;
				tail_q     <= 1'b0;
				// padding starts at the byte after the last one written
				pad_q <= in_item.byte_present ? stat.pos + 6'd1 : stat.pos;
			end
			if (state_q == ST_PAD) begin
				pad_q <= pad_q + 6'd1;
				// no room for the length after the pad byte: add a further block
				if (pad_q == 6'd63) begin
					if (stat.pos < LEN_POS || tail_q) begin
						len_done_q <= 1'b1;
					end else begin
						tail_q <= 1'b1;
					end
				end
			end
			if (state_q == ST_LOAD) rnd_q <= '0;
			if (state_q == ST_ROUND) rnd_q <= rnd_q + 6'd1;
			if (state_q == ST_FOLD && !finish_q) finish_q <= 1'b0;
			if (state_q == ST_OUT && out_ready) idx_q <= idx_q + 3'd1;
		end
	end
endmodule

### rtl/sha256_message_hasher.sv
`timescale 1ns / 1ps
// SHA-256 hasher, one message byte per input transaction.
// Input channel (in_valid/in_ready, in_item): a transaction with byte_present
//   set adds data_byte to the message; end_of_message closes the message after
//   that transaction's byte, if any. A transaction with neither does nothing.
// Output channel (out_valid/out_ready, out_item): eight transactions per
//   message, digest words 0..7, last_word set on word 7.
// Flow: a byte that does not complete a 64-byte block is written and the
//   hasher is ready for the next byte. A byte completing a block costs a load,
//   64 rounds and a fold, all in the shared round unit; the end of a message
//   adds a padding sweep over the rest of the block and one or two
//   compressions, then the digest words.
// Reset: hash words return to the initial values, byte count clears, the
//   controller goes idle; the block buffer needs no clearing.
// Stalls: the digest waits in the hash registers while out_ready is low;
//   no new input transaction is taken until all eight words have gone.
module sha256_message_hasher (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sha256_pkg::in_item_t  in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sha256_pkg::out_item_t out_item
);
	import sha256_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sha256_controller u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_item(in_item), .in_valid(in_valid), .in_ready(in_ready),
		.out_item(out_item), .out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .cmd(cmd)
	);

	sha256_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat)
	);
endmodule

### rtl/sha256_checker.sv
`timescale 1ns / 1ps
module sha256_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input sha256_pkg::out_item_t out_item
);
	import sha256_pkg::*;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken during digest");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output dropped while stalled");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.last_word == (out_item.word_index == 3'd7)))
		else $error("last flag mismatch");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_item.last_word |=>
		out_valid && out_item.word_index == $past(out_item.word_index) + 3'd1)
		else $error("word order broken");
endmodule

bind sha256_message_hasher sha256_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
);
